### rtl/wfst_pkg.sv
package wfst_pkg;

    // Field widths
    localparam int DIST_W     = 10;
    localparam int DT_W       = 16;
    localparam int TOL_W      = 11;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 8;

    // Datapath widths
    localparam int ERR_W      = 12;                  // e in -2046..2046
    localparam int PROD_W     = ERR_W + DT_W + 1;    // e * dt
    localparam int KPE_W      = ERR_W + GAIN_W + 1;  // kp * e
    localparam int INTEG_W    = 48;
    localparam int HALF_W     = INTEG_W / 2;
    localparam int PH_W       = GAIN_W + 1 + HALF_W; // ki * integral upper half
    localparam int PL_W       = GAIN_W + HALF_W;     // ki * integral lower half
    localparam int PP_W       = KPE_W + 11;          // kp * e * 1000
    localparam int SUM_W      = 64;

    // |sum| / 4096000 = (|sum| >> 15) / 125
    localparam int DIV_SHIFT  = 15;
    localparam int Q_W        = 15;
    localparam int RECIP_W    = 16;
    localparam int QK_W       = Q_W + RECIP_W;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP = 16'd33555;     // ceil(2^22 / 125)
    // Any correction of 256 or more rejects every proposal, so clamp there.
    localparam int CORR_W     = SPEED_W + 1;
    localparam logic [Q_W-1:0]    Q_SAT_LIMIT = 15'd32000; // 256 * 125
    localparam logic [CORR_W-1:0] CORR_SAT    = 9'd256;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BASELINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BASELINE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 3'd5;

    // Steering direction
    localparam logic [1:0] DIR_BAND     = 2'd0;
    localparam logic [1:0] DIR_RIGHT_UP = 2'd1; // e below -tolerance
    localparam logic [1:0] DIR_LEFT_UP  = 2'd2; // e above tolerance

    typedef struct packed {
        logic [DIST_W-1:0]  right_baseline;
        logic [DIST_W-1:0]  left_baseline;
        logic [TOL_W-1:0]   tolerance;
        logic [GAIN_W-1:0]  kp_gain;
        logic [GAIN_W-1:0]  ki_gain;
        logic [SPEED_W-1:0] max_speed;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        right_baseline: 10'd800,
        left_baseline:  10'd960,
        tolerance:      11'd100,
        kp_gain:        16'd164,
        ki_gain:        16'd164,
        max_speed:      8'd255
    };

    typedef struct packed {
        logic                      valid;
        logic [1:0]                dir;
        logic signed [KPE_W-1:0]   kpe;
        logic signed [INTEG_W-1:0] integ;
    } t_integ_res;

    typedef struct packed {
        logic              valid;
        logic [1:0]        dir;
        logic [CORR_W-1:0] corr;
    } t_corr_res;

    typedef struct packed {
        logic [SPEED_W-1:0] right_speed;
        logic [SPEED_W-1:0] left_speed;
        logic               in_band;
        logic               right_rejected;
        logic               left_rejected;
    } t_result;

endpackage

### rtl/wfst_ifs.sv
interface wfst_in_if import wfst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] right_distance;
    logic [DIST_W-1:0] left_distance;
    logic [DT_W-1:0]   elapsed_ms;

    modport source (output valid, output right_distance, output left_distance,
                    output elapsed_ms, input ready);
    modport sink   (input valid, input right_distance, input left_distance,
                    input elapsed_ms, output ready);
endinterface

interface wfst_out_if import wfst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] right_speed;
    logic [SPEED_W-1:0] left_speed;
    logic               in_band;
    logic               right_rejected;
    logic               left_rejected;

    modport source (output valid, output right_speed, output left_speed, output in_band,
                    output right_rejected, output left_rejected, input ready);
    modport sink   (input valid, input right_speed, input left_speed, input in_band,
                    input right_rejected, input left_rejected, output ready);
endinterface

interface wfst_cfg_if import wfst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wfst_cfg_regs.sv
module wfst_cfg_regs import wfst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_wr_valid) begin
            case (i_wr_index)
                CFG_RIGHT_BASELINE: r_cfg.right_baseline <= i_wr_data[DIST_W-1:0];
                CFG_LEFT_BASELINE:  r_cfg.left_baseline  <= i_wr_data[DIST_W-1:0];
                CFG_TOLERANCE:      r_cfg.tolerance      <= i_wr_data[TOL_W-1:0];
                CFG_KP_GAIN:        r_cfg.kp_gain        <= i_wr_data[GAIN_W-1:0];
                CFG_KI_GAIN:        r_cfg.ki_gain        <= i_wr_data[GAIN_W-1:0];
                CFG_MAX_SPEED:      r_cfg.max_speed      <= i_wr_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/wfst_integ.sv
module wfst_integ import wfst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIST_W-1:0] i_right_distance,
    input  logic [DIST_W-1:0] i_left_distance,
    input  logic [DT_W-1:0]   i_elapsed_ms,
    input  t_cfg              i_cfg,
    output t_integ_res        o_res
);

    // stage 1: error, deadband decision, e * dt
    logic signed [ERR_W:0]     e_wide;
    logic signed [ERR_W:0]     tol_s;
    logic signed [ERR_W-1:0]   e;
    logic signed [PROD_W-1:0]  prod;
    logic [1:0]                dir;

    logic                      r1_valid;
    logic signed [ERR_W-1:0]   r1_e;
    logic signed [PROD_W-1:0]  r1_prod;
    logic [1:0]                r1_dir;

    // stage 2: integral accumulate, kp * e
    logic signed [INTEG_W:0]   sum;
    logic signed [INTEG_W-1:0] n_int;
    logic signed [KPE_W-1:0]   kpe;

    logic signed [INTEG_W-1:0] r_int;
    logic                      r2_valid;
    logic signed [INTEG_W-1:0] r2_integ;
    logic signed [KPE_W-1:0]   r2_kpe;
    logic [1:0]                r2_dir;

    always_comb begin
        e_wide = $signed({3'b000, i_cfg.right_baseline}) - $signed({3'b000, i_right_distance})
               - $signed({3'b000, i_cfg.left_baseline}) + $signed({3'b000, i_left_distance});
        tol_s  = $signed({2'b00, i_cfg.tolerance});
        e      = e_wide[ERR_W-1:0];
        prod   = e * $signed({1'b0, i_elapsed_ms});
        if (e_wide < -tol_s) begin
            dir = DIR_RIGHT_UP;
        end else if (e_wide > tol_s) begin
            dir = DIR_LEFT_UP;
        end else begin
            dir = DIR_BAND;
        end
    end

    always_comb begin
        sum = {r_int[INTEG_W-1], r_int}
            + {{(INTEG_W + 1 - PROD_W){r1_prod[PROD_W-1]}}, r1_prod};
        // saturate when the two top bits disagree
        if (sum[INTEG_W] != sum[INTEG_W-1]) begin
            n_int = sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_int = sum[INTEG_W-1:0];
        end
        kpe = $signed({1'b0, i_cfg.kp_gain}) * r1_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r_int    <= '0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            if (r1_valid) begin
                r_int <= n_int;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_e     <= e;
            r1_prod  <= prod;
            r1_dir   <= dir;
            r2_integ <= n_int;
            r2_kpe   <= kpe;
            r2_dir   <= r1_dir;
        end
    end

    assign o_res = '{valid: r2_valid, dir: r2_dir, kpe: r2_kpe, integ: r2_integ};

    a_int_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_en && r1_valid) |=> $stable(r_int))
        else $error("integral moved without an advancing request");

    a_int_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r1_valid && !r1_prod[PROD_W-1] |=> r_int >= $past(r_int))
        else $error("integral fell on a non-negative increment");

endmodule

### rtl/wfst_corr.sv
module wfst_corr import wfst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_integ_res        i_res,
    input  logic [GAIN_W-1:0] i_ki_gain,
    output t_corr_res         o_res
);

    logic signed [PH_W-1:0]  ph;
    logic [PL_W-1:0]         pl;
    logic signed [PP_W-1:0]  kpe_x;
    logic signed [PP_W-1:0]  pp;
    logic signed [SUM_W-1:0] ph_x;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-DIV_SHIFT-1:0] q_full;
    logic                    q_sat;
    logic [QK_W-1:0]         qk;
    logic [CORR_W-1:0]       corr;

    logic r3_valid, r4_valid, r5_valid, r6_valid;
    logic [1:0]              r3_dir, r4_dir, r5_dir, r6_dir;
    logic signed [PH_W-1:0]  r3_ph;
    logic [PL_W-1:0]         r3_pl;
    logic signed [PP_W-1:0]  r3_pp;
    logic signed [SUM_W-1:0] r4_sum;
    logic [SUM_W-1:0]        r5_mag;
    logic [CORR_W-1:0]       r6_corr;

    always_comb begin
        // ki * integral as two partial products
        ph    = $signed({1'b0, i_ki_gain}) * $signed(i_res.integ[INTEG_W-1:HALF_W]);
        pl    = i_ki_gain * i_res.integ[HALF_W-1:0];
        // x * 1000 = x * 1024 - x * 16 - x * 8
        kpe_x = {{(PP_W-KPE_W){i_res.kpe[KPE_W-1]}}, i_res.kpe};
        pp    = (kpe_x <<< 10) - (kpe_x <<< 4) - (kpe_x <<< 3);
    end

    always_comb begin
        ph_x = {{(SUM_W-PH_W){r3_ph[PH_W-1]}}, r3_ph};
        sum  = (ph_x <<< HALF_W) + $signed({{(SUM_W-PL_W){1'b0}}, r3_pl})
             + $signed({{(SUM_W-PP_W){r3_pp[PP_W-1]}}, r3_pp});
    end

    assign mag = r4_sum[SUM_W-1] ? $unsigned(-r4_sum) : $unsigned(r4_sum);

    always_comb begin
        q_full = r5_mag[SUM_W-1:DIV_SHIFT];
        q_sat  = (|q_full[SUM_W-DIV_SHIFT-1:Q_W]) || (q_full[Q_W-1:0] >= Q_SAT_LIMIT);
        qk     = q_full[Q_W-1:0] * RECIP;
        corr   = q_sat ? CORR_SAT : qk[RECIP_SHIFT+CORR_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_res.valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_dir  <= i_res.dir;
            r3_ph   <= ph;
            r3_pl   <= pl;
            r3_pp   <= pp;
            r4_dir  <= r3_dir;
            r4_sum  <= sum;
            r5_dir  <= r4_dir;
            r5_mag  <= mag;
            r6_dir  <= r5_dir;
            r6_corr <= corr;
        end
    end

    assign o_res = '{valid: r6_valid, dir: r6_dir, corr: r6_corr};

endmodule

### rtl/wfst_speed.sv
module wfst_speed import wfst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_corr_res          i_res,
    input  logic [SPEED_W-1:0] i_max_speed,
    output logic               o_valid,
    output t_result            o_result
);

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               rej;
    } t_prop;

    function automatic t_prop propose(input logic [SPEED_W-1:0] old,
                                      input logic [CORR_W-1:0]  corr,
                                      input logic               raise,
                                      input logic [SPEED_W-1:0] max_s);
        logic [SPEED_W+1:0] value;
        t_prop              res;
        // top bit set means the proposal went negative
        value = raise ? ({2'b00, old} + {1'b0, corr}) : ({2'b00, old} - {1'b0, corr});
        res.rej   = value[SPEED_W+1] || (value[SPEED_W:0] > {1'b0, max_s});
        res.speed = res.rej ? old : value[SPEED_W-1:0];
        return res;
    endfunction

    logic               r_valid;
    logic [SPEED_W-1:0] r_rspeed, r_lspeed;
    logic               r_in_band, r_rrej, r_lrej;

    t_prop              prop_r, prop_l;
    logic [SPEED_W-1:0] n_rspeed, n_lspeed;
    logic               n_in_band, n_rrej, n_lrej;

    always_comb begin
        prop_r    = propose(r_rspeed, i_res.corr, i_res.dir == DIR_RIGHT_UP, i_max_speed);
        prop_l    = propose(r_lspeed, i_res.corr, i_res.dir == DIR_LEFT_UP, i_max_speed);
        n_rspeed  = r_rspeed;
        n_lspeed  = r_lspeed;
        n_in_band = 1'b0;
        n_rrej    = 1'b0;
        n_lrej    = 1'b0;
        case (i_res.dir)
            DIR_RIGHT_UP, DIR_LEFT_UP: begin
                n_rspeed = prop_r.speed;
                n_lspeed = prop_l.speed;
                n_rrej   = prop_r.rej;
                n_lrej   = prop_l.rej;
            end
            DIR_BAND: begin
                n_rspeed  = i_max_speed;
                n_lspeed  = i_max_speed;
                n_in_band = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_rspeed  <= '0;
            r_lspeed  <= '0;
            r_in_band <= 1'b0;
            r_rrej    <= 1'b0;
            r_lrej    <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_res.valid;
            if (i_res.valid) begin
                r_rspeed  <= n_rspeed;
                r_lspeed  <= n_lspeed;
                r_in_band <= n_in_band;
                r_rrej    <= n_rrej;
                r_lrej    <= n_lrej;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = '{right_speed: r_rspeed, left_speed: r_lspeed, in_band: r_in_band,
                        right_rejected: r_rrej, left_rejected: r_lrej};

    a_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_res.valid && i_res.dir == DIR_BAND
        |=> r_valid && r_in_band && !r_rrej && !r_lrej)
        else $error("in-band step did not produce a clean in-band result");

    a_rej_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_res.valid && n_rrej |=> r_rspeed == $past(r_rspeed))
        else $error("rejected right proposal changed the speed");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_rspeed) && $stable(r_lspeed) && $stable(r_valid))
        else $error("result register moved during a stall");

endmodule

### rtl/wall_follow_pi_speed_trim_top.sv
// PI wall-follow speed trim with deadband.
//
// i_in carries one request per control step: right and left averaged wall
// distances and the milliseconds since the previous step. o_out returns one
// result per request, in order: both wheel speeds now applied, the in-band
// flag and a rejected flag per wheel. i_cfg writes one register per request
// (index, data); it is always ready and should only be used while idle.
//
// One request is accepted per cycle unless o_out stalls: the datapath is an
// input register, six pipeline stages (error and e*dt, integral update,
// gain partial products, 64-bit sum, magnitude, divide by 4096000 via
// reciprocal multiply) and the result register.
// The integral and wheel speeds are updated in loops through one register at
// their stages, so back-to-back requests see each other's state correctly.
//
// When o_out.ready is low with a result pending, the whole pipeline holds
// and i_in.ready drops until the result is taken. Reset clears all valids,
// the integral and both speeds, and loads the register defaults.
module wall_follow_pi_speed_trim_top import wfst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wfst_in_if.sink    i_in,
    wfst_out_if.source o_out,
    wfst_cfg_if.sink   i_cfg
);

    t_cfg        cfg;
    t_integ_res  integ_res;
    t_corr_res   corr_res;
    t_result     result;
    logic        out_valid;
    logic        en;

    logic              r_s0_valid;
    logic [DIST_W-1:0] r_s0_rd;
    logic [DIST_W-1:0] r_s0_ld;
    logic [DT_W-1:0]   r_s0_dt;

    assign en          = !out_valid || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_rd <= i_in.right_distance;
            r_s0_ld <= i_in.left_distance;
            r_s0_dt <= i_in.elapsed_ms;
        end
    end

    wfst_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    wfst_integ u_integ (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (r_s0_valid),
        .i_right_distance (r_s0_rd),
        .i_left_distance  (r_s0_ld),
        .i_elapsed_ms     (r_s0_dt),
        .i_cfg            (cfg),
        .o_res            (integ_res)
    );

    wfst_corr u_corr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_res     (integ_res),
        .i_ki_gain (cfg.ki_gain),
        .o_res     (corr_res)
    );

    wfst_speed u_speed (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_res       (corr_res),
        .i_max_speed (cfg.max_speed),
        .o_valid     (out_valid),
        .o_result    (result)
    );

    assign o_out.valid          = out_valid;
    assign o_out.right_speed    = result.right_speed;
    assign o_out.left_speed     = result.left_speed;
    assign o_out.in_band        = result.in_band;
    assign o_out.right_rejected = result.right_rejected;
    assign o_out.left_rejected  = result.left_rejected;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import wfst_pkg::*; ();

    localparam int     LATENCY   = 7;
    localparam longint INTEG_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO  = -INTEG_HI - 1;
    localparam longint CORR_DIV  = 64'sd4096000;
    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Tracks registers, wheel speeds and the error integral; holds the
    // expected result of every accepted request in order.
    class speed_trim_scoreboard;
        t_cfg               regs;
        logic [SPEED_W-1:0] right_spd;
        logic [SPEED_W-1:0] left_spd;
        longint             integ;
        t_result            pending[$];
        int                 errors;
        int                 n_checked;
        int                 n_band;
        int                 n_right_rej;
        int                 n_left_rej;

        function new();
            regs      = CFG_RESET;
            right_spd = '0;
            left_spd  = '0;
            integ     = 0;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            if (errors <= 40) begin
                $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            end
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RIGHT_BASELINE: regs.right_baseline = data[DIST_W-1:0];
                CFG_LEFT_BASELINE:  regs.left_baseline  = data[DIST_W-1:0];
                CFG_TOLERANCE:      regs.tolerance      = data[TOL_W-1:0];
                CFG_KP_GAIN:        regs.kp_gain        = data[GAIN_W-1:0];
                CFG_KI_GAIN:        regs.ki_gain        = data[GAIN_W-1:0];
                CFG_MAX_SPEED:      regs.max_speed      = data[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [DIST_W-1:0] rd, logic [DIST_W-1:0] ld,
                                   logic [DT_W-1:0] dt);
            longint     err;
            longint     tol;
            longint     top;
            longint     sum;
            longint     mag;
            longint     corr;
            longint     r_new;
            longint     l_new;
            logic [1:0] dir;
            t_result    res;
            err = (longint'(regs.right_baseline) - longint'(rd))
                - (longint'(regs.left_baseline) - longint'(ld));
            integ = integ + err * longint'(dt);
            if (integ > INTEG_HI) integ = INTEG_HI;
            if (integ < INTEG_LO) integ = INTEG_LO;
            sum  = longint'(regs.kp_gain) * err * 1000 + longint'(regs.ki_gain) * integ;
            mag  = (sum < 0) ? -sum : sum;
            corr = mag / CORR_DIV;
            tol  = longint'(regs.tolerance);
            top  = longint'(regs.max_speed);
            res  = '0;
            if (err < -tol) dir = DIR_RIGHT_UP;
            else if (err > tol) dir = DIR_LEFT_UP;
            else dir = DIR_BAND;
            r_new = longint'(right_spd);
            l_new = longint'(left_spd);
            case (dir)
                DIR_RIGHT_UP: begin
                    r_new = r_new + corr;
                    l_new = l_new - corr;
                end
                DIR_LEFT_UP: begin
                    r_new = r_new - corr;
                    l_new = l_new + corr;
                end
                default: ;
            endcase
            if (dir == DIR_BAND) begin
                right_spd   = regs.max_speed;
                left_spd    = regs.max_speed;
                res.in_band = 1'b1;
            end else begin
                // a rejected wheel keeps its old speed, even one above max_speed
                if (r_new < 0 || r_new > top) res.right_rejected = 1'b1;
                else right_spd = r_new[SPEED_W-1:0];
                if (l_new < 0 || l_new > top) res.left_rejected = 1'b1;
                else left_spd = l_new[SPEED_W-1:0];
            end
            res.right_speed = right_spd;
            res.left_speed  = left_spd;
            pending.push_back(res);
        endfunction

        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report_mismatch("result with no request", 1, 0);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (want.in_band) n_band++;
            if (want.right_rejected) n_right_rej++;
            if (want.left_rejected) n_left_rej++;
            if (got.right_speed != want.right_speed)
                report_mismatch("right_speed", longint'(got.right_speed),
                                longint'(want.right_speed));
            if (got.left_speed != want.left_speed)
                report_mismatch("left_speed", longint'(got.left_speed),
                                longint'(want.left_speed));
            if (got.in_band != want.in_band)
                report_mismatch("in_band", longint'(got.in_band), longint'(want.in_band));
            if (got.right_rejected != want.right_rejected)
                report_mismatch("right_rejected", longint'(got.right_rejected),
                                longint'(want.right_rejected));
            if (got.left_rejected != want.left_rejected)
                report_mismatch("left_rejected", longint'(got.left_rejected),
                                longint'(want.left_rejected));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    wfst_in_if  in_if ();
    wfst_out_if out_if ();
    wfst_cfg_if cfg_if ();

    wall_follow_pi_speed_trim_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    speed_trim_scoreboard sb = new();

    bit          sender_idles;
    bit          sink_idles;
    int unsigned hold_cycles;
    longint      gen_integ;   // running e*dt as the stimulus sees it
    int          n_settings;
    t_result     seen_result;

    assign seen_result = {out_if.right_speed, out_if.left_speed, out_if.in_band,
                          out_if.right_rejected, out_if.left_rejected};

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still outstanding", sb.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_request(in_if.right_distance, in_if.left_distance, in_if.elapsed_ms);
            if (out_if.valid && out_if.ready) sb.check_result(seen_result);
        end
    end

    // result side: random stalls between ready stretches
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (sink_idles && $urandom_range(0, 99) < 12) begin
            out_if.ready <= 1'b0;
            hold_cycles  <= $urandom_range(0, 8);
        end else begin
            out_if.ready <= 1'b1;
            hold_cycles  <= sink_idles ? $urandom_range(0, 15) : 0;
        end
    end

    function automatic t_cfg make_cfg(int rb, int lb, int tol, int kp, int ki, int mx);
        t_cfg c;
        c.right_baseline = rb[DIST_W-1:0];
        c.left_baseline  = lb[DIST_W-1:0];
        c.tolerance      = tol[TOL_W-1:0];
        c.kp_gain        = kp[GAIN_W-1:0];
        c.ki_gain        = ki[GAIN_W-1:0];
        c.max_speed      = mx[SPEED_W-1:0];
        return c;
    endfunction

    function automatic t_cfg random_cfg();
        int tol;
        int kp;
        int ki;
        int mx;
        tol = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 300) : $urandom_range(0, 2047);
        kp  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2000) : $urandom_range(0, 65535);
        ki  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 500) : $urandom_range(0, 65535);
        mx  = $urandom_range(0, 255);
        return make_cfg($urandom_range(0, 1023), $urandom_range(0, 1023), tol, kp, ki, mx);
    endfunction

    // let the last accepted request reach the scoreboard before draining
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        repeat (LATENCY + 4) @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
    endtask

    // unused upper data bits carry junk; the block must mask them off
    task automatic apply_config(t_cfg c);
        logic [CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = CFG_DATA_W'($urandom);
        cfg_write(CFG_RIGHT_BASELINE, {junk[CFG_DATA_W-1:DIST_W], c.right_baseline});
        junk = CFG_DATA_W'($urandom);
        cfg_write(CFG_SPARE_A, junk);
        cfg_write(CFG_LEFT_BASELINE, {junk[CFG_DATA_W-1:DIST_W], c.left_baseline});
        junk = CFG_DATA_W'($urandom);
        cfg_write(CFG_TOLERANCE, {junk[CFG_DATA_W-1:TOL_W], c.tolerance});
        cfg_write(CFG_KP_GAIN, c.kp_gain);
        cfg_write(CFG_KI_GAIN, c.ki_gain);
        junk = CFG_DATA_W'($urandom);
        cfg_write(CFG_MAX_SPEED, {junk[CFG_DATA_W-1:SPEED_W], c.max_speed});
        cfg_write(CFG_SPARE_B, ~junk);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic send_request(int rd, int ld, int dt);
        if (sender_idles && $urandom_range(0, 99) < 15) begin
            in_if.valid          <= 1'b0;
            in_if.right_distance <= DIST_W'($urandom);
            in_if.left_distance  <= DIST_W'($urandom);
            in_if.elapsed_ms     <= DT_W'($urandom);
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.right_distance <= rd[DIST_W-1:0];
        in_if.left_distance  <= ld[DIST_W-1:0];
        in_if.elapsed_ms     <= dt[DT_W-1:0];
        gen_integ += longint'((int'(sb.regs.right_baseline) - rd)
                            - (int'(sb.regs.left_baseline) - ld)) * dt;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
    endtask

    // Mostly samples that land near the deadband, with the error sign biased
    // to pull the integral back toward zero; the rest is raw noise.
    task automatic send_steered();
        int rb;
        int lb;
        int tol;
        int e;
        int lo;
        int hi;
        int rd;
        int ld;
        int dt;
        int pick;
        rb   = int'(sb.regs.right_baseline);
        lb   = int'(sb.regs.left_baseline);
        tol  = int'(sb.regs.tolerance);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            send_request($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 65535));
            return;
        end
        if (pick < 45) e = $urandom_range(0, tol);
        else if (pick < 75) e = tol + $urandom_range(1, 40);
        else e = tol + $urandom_range(1, 600);
        if ($urandom_range(0, 9) < ((gen_integ > 0) ? 7 : 3)) e = -e;
        // clamp to what the distances can produce under these baselines
        if (e < rb - lb - 1023) e = rb - lb - 1023;
        if (e > rb - lb + 1023) e = rb - lb + 1023;
        lo = (rb - lb - e > 0) ? rb - lb - e : 0;
        hi = (1023 + rb - lb - e < 1023) ? 1023 + rb - lb - e : 1023;
        rd = $urandom_range(lo, hi);
        ld = e + rd - rb + lb;
        pick = $urandom_range(0, 99);
        if (pick < 70) dt = $urandom_range(0, 30);
        else if (pick < 85) dt = $urandom_range(31, 1000);
        else if (pick < 95) dt = $urandom_range(0, 65535);
        else dt = ($urandom_range(0, 1) == 1) ? 65535 : 0;
        send_request(rd, ld, dt);
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.right_distance <= '0;
        in_if.left_distance  <= '0;
        in_if.elapsed_ms     <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= '0;
        cfg_if.data          <= '0;
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        gen_integ    = 0;
        n_settings   = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: deadband edges, both steering directions, dt extremes
        send_request(800, 960, 0);
        send_request(700, 960, 10);
        send_request(699, 960, 10);
        send_request(900, 960, 10);
        send_request(901, 960, 10);
        send_request(0, 1023, 65535);
        send_request(1023, 0, 65535);
        send_request(800, 960, 65535);
        repeat (110) send_steered();

        // zero deadband, largest kp, no integral action
        apply_config(make_cfg(1023, 0, 0, 65535, 0, 255));
        send_request(0, 1023, 65535);
        send_request(1023, 0, 0);
        send_request(1023, 1, 0);
        send_request(1022, 0, 3);
        repeat (60) send_steered();

        // widest deadband, max_speed of zero, largest ki
        apply_config(make_cfg(0, 1023, 2047, 0, 65535, 0));
        send_request(1023, 0, 65535);
        send_request(0, 1023, 0);
        repeat (40) send_steered();

        // stored speeds left above a lowered max_speed
        apply_config(make_cfg(512, 512, 10, 0, 0, 255));
        gen_integ = 0;
        send_request(512, 512, 5);
        apply_config(make_cfg(512, 512, 10, 0, 0, 100));
        send_request(400, 512, 7);
        send_request(600, 512, 3);
        send_request(512, 512, 0);
        send_request(400, 512, 9);
        apply_config(make_cfg(512, 512, 10, 300, 40, 100));
        repeat (110) send_steered();

        repeat (3) begin
            apply_config(random_cfg());
            repeat (110) send_steered();
        end

        apply_config(random_cfg());
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        repeat (110) send_steered();

        wait_idle();
        if (sb.pending.size() != 0)
            sb.report_mismatch("requests left without a result",
                               longint'(sb.pending.size()), 0);
        $display("Checked %0d control steps under %0d register settings.",
                 sb.n_checked, n_settings);
        $display("In band %0d times; right rejected %0d, left rejected %0d; %0d mismatches.",
                 sb.n_band, sb.n_right_rej, sb.n_left_rej, sb.errors);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### wall_follow_pi_speed_trim_top.f
rtl/wfst_pkg.sv
rtl/wfst_ifs.sv
rtl/wfst_cfg_regs.sv
rtl/wfst_integ.sv
rtl/wfst_corr.sv
rtl/wfst_speed.sv
rtl/wall_follow_pi_speed_trim_top.sv
sim/tb_top.sv
